// ----- hdl/bspl_pkg.sv -----
// Shared constants for the uniform cubic B-spline basis evaluator.
// No dependencies; used by the interfaces, the core and the checker.
package bspl_pkg;

  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int SEG_W  = 9;
  localparam int IDX_W  = 9;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic {
    REG_SEGMENTS = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_t;

  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(1);

endpackage

// ----- hdl/bspl_chan_if.sv -----
// Valid/ready channels for input and result words of the B-spline evaluator.
// Depends on bspl_pkg for the index width.
interface bspl_in_if #(
  parameter int PW = bspl_pkg::FRAC_BITS_DEF + 1
);
  logic                        valid;
  logic                        ready;
  logic [bspl_pkg::IDX_W-1:0]  basis_index;
  logic [PW-1:0]               position;

  modport source (output valid, output basis_index, output position, input ready);
  modport sink   (input valid, input basis_index, input position, output ready);
endinterface

interface bspl_out_if #(
  parameter int PW = bspl_pkg::FRAC_BITS_DEF + 1
);
  logic                 valid;
  logic                 ready;
  logic [PW-1:0]        basis_value;
  logic signed [PW-1:0] basis_slope;

  modport source (output valid, output basis_value, output basis_slope, input ready);
  modport sink   (input valid, input basis_value, input basis_slope, output ready);
endinterface

// ----- hdl/cubic_bspline_basis_eval_core.sv -----
// Uniform cubic B-spline basis value and slope, eight-stage pipeline.
// Depends on bspl_pkg and the channel interfaces in bspl_chan_if.sv.
//
// Takes one word per cycle when the output is not stalled and gives one result
// word per input word, in order. The pipeline holds the position-by-segments
// product, the two squaring and cubing multiply rounds on the local fraction and
// its complement, the piece selection, and the divide-by-three done as a
// reciprocal multiply. Stalls on the output only hold full stages; empty stages
// still take new words. The segment count is written over the APB port at byte
// address 0 (zero reads as one, values above MAX_SEGMENTS are clamped); the user
// must write it only while idle, as the block itself does not enforce this.
module cubic_bspline_basis_eval_core #(
  parameter int MAX_SEGMENTS = bspl_pkg::MAX_SEGMENTS_DEF,
  parameter int FRAC_BITS    = bspl_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bspl_in_if.sink                       in_ch,
  bspl_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bspl_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [bspl_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [bspl_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int F     = FRAC_BITS;
  localparam int PW    = F + 1;
  localparam int SW    = bspl_pkg::SEG_W;
  localparam int XW    = PW + SW;
  localparam int SQW   = 2 * F + 1;
  localparam int CUW   = 2 * F + 2;
  localparam int VW    = F + 5;
  localparam int WW    = F + 2;
  localparam int DIV_K = WW + 2;
  localparam int PRW   = 2 * WW + 1;
  localparam int NSTG  = 8;

  localparam logic [WW:0]     DIV_M  = (WW+1)'(((64'd1 << DIV_K) + 64'd2) / 64'd3);
  localparam logic [SQW-1:0]  HALF_S = SQW'(1) << (F - 1);
  localparam logic [CUW-1:0]  HALF_C = CUW'(1) << (F - 1);
  localparam logic [PW-1:0]   ONE_P  = PW'(1) << F;
  localparam logic signed [VW-1:0] K1  = VW'(1);
  localparam logic signed [VW-1:0] K2  = VW'(2);
  localparam logic signed [VW-1:0] K3  = VW'(3);
  localparam logic signed [VW-1:0] K4  = VW'(4);
  localparam logic signed [VW-1:0] K6  = VW'(6);
  localparam logic signed [VW-1:0] ONE_S = VW'(1) << F;

  // configuration
  logic [SW-1:0] seg_r, seg_nxt;
  logic          cfg_wr;
  logic [SW-1:0] wr_val;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (bspl_pkg::reg_idx_t'(cfg_paddr[2]) == bspl_pkg::REG_SEGMENTS);
  assign wr_val     = cfg_pwdata[SW-1:0];

  always_comb begin
    seg_nxt = seg_r;
    if (cfg_wr) begin
      if (wr_val == '0) begin
        seg_nxt = SW'(1);
      end else if (32'(wr_val) > 32'(MAX_SEGMENTS)) begin
        seg_nxt = SW'(MAX_SEGMENTS);
      end else begin
        seg_nxt = wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= bspl_pkg::SEG_RESET;
    end else begin
      seg_r <= seg_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (bspl_pkg::reg_idx_t'(cfg_paddr[2]) == bspl_pkg::REG_SEGMENTS) begin
      cfg_prdata = bspl_pkg::DATA_W'(seg_r);
    end
  end

  // pipeline control: a stage advances when empty or when the next one advances
  logic [NSTG-1:0] vld_r, vld_nxt, en;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = vld_r[NSTG-1];

  // stage 1: scaled position
  logic [SW-1:0] idx1_r;
  logic [XW-1:0] x1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      idx1_r <= in_ch.basis_index;
      x1_r   <= XW'(in_ch.position) * XW'(seg_r);
    end
  end

  // stage 2: piece select, support, fraction squares
  logic [SW:0]    xint;
  logic [SW+1:0]  sfull;
  logic [F-1:0]   frac;
  logic [PW-1:0]  gcomp;
  logic [1:0]     sel2_r;
  logic           sup2_r;
  logic [F-1:0]   fr2_r;
  logic [PW-1:0]  gm2_r;
  logic [SQW-1:0] ff2_r, gg2_r;

  assign xint  = x1_r[XW-1:F];
  assign sfull = (SW+2)'(xint) + (SW+2)'(3) - (SW+2)'(idx1_r);
  assign frac  = x1_r[F-1:0];
  assign gcomp = ONE_P - PW'(frac);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sel2_r <= sfull[1:0];
      sup2_r <= (sfull[SW+1:2] == '0);
      fr2_r  <= frac;
      gm2_r  <= gcomp;
      ff2_r  <= SQW'(frac) * SQW'(frac);
      gg2_r  <= SQW'(gcomp) * SQW'(gcomp);
    end
  end

  // stage 3: round squares
  logic [1:0]    sel3_r;
  logic          sup3_r;
  logic [F-1:0]  fr3_r;
  logic [PW-1:0] gm3_r, fsq3_r, gsq3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sel3_r <= sel2_r;
      sup3_r <= sup2_r;
      fr3_r  <= fr2_r;
      gm3_r  <= gm2_r;
      fsq3_r <= PW'((ff2_r + HALF_S) >> F);
      gsq3_r <= PW'((gg2_r + HALF_S) >> F);
    end
  end

  // stage 4: cube products
  logic [1:0]     sel4_r;
  logic           sup4_r;
  logic [F-1:0]   fr4_r;
  logic [PW-1:0]  fsq4_r, gsq4_r;
  logic [CUW-1:0] fcu4_r, gcu4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sel4_r <= sel3_r;
      sup4_r <= sup3_r;
      fr4_r  <= fr3_r;
      fsq4_r <= fsq3_r;
      gsq4_r <= gsq3_r;
      fcu4_r <= CUW'(fsq3_r) * CUW'(fr3_r);
      gcu4_r <= CUW'(gsq3_r) * CUW'(gm3_r);
    end
  end

  // stage 5: round cubes
  logic [1:0]    sel5_r;
  logic          sup5_r;
  logic [F-1:0]  fr5_r;
  logic [PW-1:0] fsq5_r, gsq5_r, fcb5_r, gcb5_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sel5_r <= sel4_r;
      sup5_r <= sup4_r;
      fr5_r  <= fr4_r;
      fsq5_r <= fsq4_r;
      gsq5_r <= gsq4_r;
      fcb5_r <= PW'((fcu4_r + HALF_C) >> F);
      gcb5_r <= PW'((gcu4_r + HALF_C) >> F);
    end
  end

  // stage 6: piece polynomials, halve, floor at zero
  logic signed [VW-1:0] f_s, fq_s, fc_s, gq_s, gc_s, vnum, snum, sr;
  logic [VW-1:0]        vu;
  logic [WW-1:0]        w6_r;
  logic [PW-1:0]        slope6_r;

  assign f_s  = $signed(VW'(fr5_r));
  assign fq_s = $signed(VW'(fsq5_r));
  assign fc_s = $signed(VW'(fcb5_r));
  assign gq_s = $signed(VW'(gsq5_r));
  assign gc_s = $signed(VW'(gcb5_r));

  always_comb begin
    unique case (sel5_r)
      2'd0: begin
        vnum = fc_s;
        snum = fq_s;
      end
      2'd1: begin
        vnum = K3 * (fq_s + f_s - fc_s) + ONE_S;
        snum = K2 * f_s - K3 * fq_s + ONE_S;
      end
      2'd2: begin
        vnum = K3 * fc_s - K6 * fq_s + K4 * ONE_S;
        snum = K3 * fq_s - K4 * f_s;
      end
      default: begin
        vnum = gc_s;
        snum = -gq_s;
      end
    endcase
    if (!sup5_r) begin
      vnum = '0;
      snum = '0;
    end
    vu = (vnum < 0) ? '0 : $unsigned(vnum);
    sr = (snum + K1) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      w6_r     <= WW'((vu + VW'(3)) >> 1);
      slope6_r <= sr[PW-1:0];
    end
  end

  // stage 7: divide by three via reciprocal
  logic [PRW-1:0] prod7_r;
  logic [PW-1:0]  slope7_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      prod7_r  <= PRW'(w6_r) * PRW'(DIV_M);
      slope7_r <= slope6_r;
    end
  end

  // stage 8: output word
  logic [PW-1:0] value8_r, slope8_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      value8_r <= PW'(prod7_r >> DIV_K);
      slope8_r <= slope7_r;
    end
  end

  assign out_ch.basis_value = value8_r;
  assign out_ch.basis_slope = $signed(slope8_r);

endmodule

// ----- hdl/bspl_checker.sv -----
// Port-level checks on the B-spline evaluator's result channel, bound to the core.
// Depends on bspl_pkg and cubic_bspline_basis_eval_core.
module bspl_checker #(
  parameter int FRAC_BITS = bspl_pkg::FRAC_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [FRAC_BITS:0]   out_value,
  input logic [FRAC_BITS:0]   out_slope
);

  localparam longint ONE  = longint'(1) << FRAC_BITS;
  localparam longint VMAX = (2 * ONE) / 3 + 1;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_value_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> longint'(out_value) <= VMAX)
    else $error("basis value above two thirds");

  a_slope_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (longint'($signed(out_slope)) <= VMAX) &&
                  (longint'($signed(out_slope)) >= -VMAX))
    else $error("basis slope out of range");

endmodule

bind cubic_bspline_basis_eval_core bspl_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_bspl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.basis_value),
  .out_slope (out_ch.basis_slope)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for cubic_bspline_basis_eval_core: streams basis index and
// position words under random idling and checks each result word against a predictor.
// Depends on bspl_pkg, the channel interfaces in bspl_chan_if.sv and the core.
module testbench;

  localparam int     FB          = bspl_pkg::FRAC_BITS_DEF;
  localparam int     AW          = bspl_pkg::ADDR_W;
  localparam int     DW          = bspl_pkg::DATA_W;
  localparam int     IW          = bspl_pkg::IDX_W;
  localparam int     SGW         = bspl_pkg::SEG_W;
  localparam int     MAX_SEG     = bspl_pkg::MAX_SEGMENTS_DEF;
  localparam int     PW          = FB + 1;
  localparam longint ONE_Q       = longint'(1) << FB;
  localparam longint HALF_Q      = longint'(1) << (FB - 1);
  localparam int     ONE_I       = 1 << FB;
  localparam int     PIPE_DEPTH  = 10;
  localparam int     N_PHASES    = 11;
  localparam int     WORDS_PHASE = 77;
  localparam int     N_DIRECTED  = 22;
  localparam int     MAX_REPORTS = 10;

  localparam logic [AW-1:0] ADDR_SEGMENTS = AW'(4 * int'(bspl_pkg::REG_SEGMENTS));
  localparam logic [AW-1:0] ADDR_NONE     = AW'(4 * int'(bspl_pkg::REG_NONE));

  typedef struct packed {
    logic [PW-1:0]        value;
    logic signed [PW-1:0] slope;
  } basis_word_t;

  class basis_scoreboard;
    basis_word_t expected_q[$];
    longint      seg_count;
    int unsigned failures;

    function new();
      seg_count = longint'(bspl_pkg::SEG_RESET);
      failures  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_segments(logic [DW-1:0] data);
      logic [SGW-1:0] v;
      v = data[SGW-1:0];
      if (v == 0) v = 1;
      seg_count = (v > MAX_SEG) ? longint'(MAX_SEG) : longint'(v);
    endfunction

    function longint mul_q(longint a, longint b);
      return (a * b + HALF_Q) >>> FB;
    endfunction

    function void note_word(logic [IW-1:0] idx, logic [PW-1:0] pos);
      longint t, f, g, f2, f3, g2, g3, vnum, snum;
      basis_word_t w;
      t = longint'(pos) * seg_count - (longint'(idx) - 3) * ONE_Q;
      vnum = 0;
      snum = 0;
      if (t >= 0 && t < 4 * ONE_Q) begin
        f  = t % ONE_Q;
        g  = ONE_Q - f;
        f2 = mul_q(f, f);
        f3 = mul_q(f2, f);
        g2 = mul_q(g, g);
        g3 = mul_q(g2, g);
        unique case (t / ONE_Q)
          0: begin
            vnum = f3;
            snum = f2;
          end
          1: begin
            vnum = -3 * f3 + 3 * f2 + 3 * f + ONE_Q;
            snum = -3 * f2 + 2 * f + ONE_Q;
          end
          2: begin
            vnum = 3 * f3 - 6 * f2 + 4 * ONE_Q;
            snum = 3 * f2 - 4 * f;
          end
          default: begin
            vnum = g3;
            snum = -g2;
          end
        endcase
      end
      if (vnum < 0) vnum = 0;
      w.value = PW'((vnum + 3) / 6);
      w.slope = PW'(((snum + 4 * ONE_Q + 1) >>> 1) - 2 * ONE_Q);
      expected_q.push_back(w);
    endfunction

    function void check_word(logic [PW-1:0] value, logic signed [PW-1:0] slope);
      basis_word_t w;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected word: value %0d slope %0d", value, slope);
      end else begin
        w = expected_q.pop_front();
        if (w.value !== value || w.slope !== slope) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("mismatch: expected value %0d slope %0d, got value %0d slope %0d",
                     w.value, w.slope, value, slope);
        end
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          cfg_psel;
  logic          cfg_penable;
  logic          cfg_pwrite;
  logic [AW-1:0] cfg_paddr;
  logic [DW-1:0] cfg_pwdata;
  logic [DW-1:0] cfg_prdata;
  logic          cfg_pready;
  bit            in_quiet  = 1'b0;
  bit            out_quiet = 1'b0;

  basis_scoreboard sb = new();

  bspl_in_if  #(.PW(PW)) in_ch ();
  bspl_out_if #(.PW(PW)) out_ch ();

  cubic_bspline_basis_eval_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // each piece at both ends, position above one, index past the support
  int dir_idx [N_DIRECTED] = '{3, 3, 3, 3, 3, 2, 2, 2, 2, 1, 1,
                               1, 0, 0, 0, 0, 4, 4, 511, 0, 2, 258};
  int dir_pos [N_DIRECTED] = '{0, 1, 32768, 65535, 65536, 0, 32768, 65535, 65536,
                               32768, 65535, 65536, 0, 43690, 65535, 65536,
                               65535, 65536, 131071, 131071, 131071, 65536};

  logic [DW-1:0] cfg_vals [6] = '{32'd256, 32'd0, 32'h0000_01FF, 32'd2,
                                  32'd300, 32'hABCD_E003};

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic send_word(logic [IW-1:0] idx, logic [PW-1:0] pos);
    int gap;
    if ($urandom_range(0, 31) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.basis_index <= idx;
    in_ch.position    <= pos;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(idx, pos);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_reg(logic [AW-1:0] addr, logic [DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_SEGMENTS) sb.set_segments(data);
    @(posedge clk);
  endtask

  initial begin
    int            idx;
    logic [PW-1:0] pos;
    logic [DW-1:0] data;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.basis_index <= '0;
    in_ch.position    <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_word(IW'(dir_idx[i]), PW'(dir_pos[i]));

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        if (p == 4) write_reg(ADDR_NONE, 32'h0000_0055);
        data = (p <= 6) ? cfg_vals[p-1] : DW'($urandom_range(1, MAX_SEG));
        write_reg(ADDR_SEGMENTS, data);
      end
      for (int k = 0; k < WORDS_PHASE; k++) begin
        if (k == WORDS_PHASE / 2 && p % 4 == 1) wait_idle();
        if ($urandom_range(0, 4) == 0) begin
          pos = PW'($urandom_range(0, (1 << PW) - 1));
          idx = $urandom_range(0, (1 << IW) - 1);
        end else begin
          // aim the index so the point lands on one of the four pieces
          if ($urandom_range(0, 15) == 0)
            pos = $urandom_range(0, 1) ? PW'(ONE_I) : '0;
          else
            pos = PW'($urandom_range(0, ONE_I));
          idx = int'((longint'(pos) * sb.seg_count) >>> FB) + 3
                - $urandom_range(0, 3);
          if (idx < 0) idx = 0;
          if (idx > (1 << IW) - 1) idx = (1 << IW) - 1;
        end
        send_word(IW'(idx), pos);
      end
    end

    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_word(out_ch.basis_value, out_ch.basis_slope);
    end
  end

  initial begin
    #1600000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bspl_pkg.sv
hdl/bspl_chan_if.sv
hdl/cubic_bspline_basis_eval_core.sv
hdl/bspl_checker.sv
sim/testbench.sv
